// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the meter RTL.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/cpfm_pkg.sv -----
// Package for the capture period frequency meter: field widths, register
// indexes, request codes and reset values. No dependencies.
package cpfm_pkg;

   // Field and accumulator widths
   localparam int TIMER_WIDTH_DEF = 16;
   localparam int STAMP_W         = 16;
   localparam int RATE_W          = 24;
   localparam int BAND_W          = 16;
   localparam int SUM_W           = 32;
   localparam int CNT_W           = 16;
   localparam int FREQ_W          = 32;

   // Frequency scale factor and the width of the full-precision numerator
   localparam int                 SCALE_W = 14;
   localparam logic [SCALE_W-1:0] SCALE   = 14'd10000;
   localparam int                 NUM_W   = SCALE_W + RATE_W + CNT_W;
   localparam int                 KMUL_W  = SCALE_W + RATE_W;

   // Sequencer step counter
   localparam int STEP_W = $clog2(NUM_W);

   // Configuration register indexes
   localparam int               CSR_IDX_W     = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH = 2'd2;

   // Configuration reset values
   localparam logic [RATE_W-1:0] TICK_RATE_RST = 24'd1000000;
   localparam logic [BAND_W-1:0] BAND_LOW_RST  = 16'd18181;
   localparam logic [BAND_W-1:0] BAND_HIGH_RST = 16'd22222;

   // Request function codes
   localparam logic FUNC_CAPTURE = 1'b0;
   localparam logic FUNC_READ    = 1'b1;

endpackage

// ----- hw/rtl/capture_period_frequency_meter_unit.sv -----
// Capture period frequency meter, top level.
// Depends on cpfm_pkg and assert_macros.svh.
//
// - Request channel (req_valid/req_ready): req_func selects a capture, with
//   req_stamp the timer value latched at the input edge, or a read. A capture
//   updates the period sums and counts at the edge it is taken and returns
//   nothing. A read returns one response and clears the sums and counts.
// - Response channel (rsp_valid/rsp_ready): frequency times 10000 for all
//   periods and for in-band periods, plus both period counts.
// - Config port (csr_we/csr_index/csr_wdata): tick rate, band low, band high;
//   write only while no read is in progress.
// - Read sequence: after acceptance a read runs a shift-add multiply by the
//   count, then restoring division (one quotient bit per step), then loads the
//   output register; both frequencies in parallel.
// - Throughput: captures every cycle while idle; req_ready is low while a read
//   is worked on, so no new request is taken until its response is loaded.
// - A finished read holds until the previous response is taken; captures are
//   not taken then, but are taken while a loaded response waits.
// - Reset clears sums, counts, last stamp and response valid and loads the
//   default config values.
module capture_period_frequency_meter_unit #(
   parameter int TIMER_WIDTH = cpfm_pkg::TIMER_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic [cpfm_pkg::STAMP_W-1:0]     req_stamp,
   // Response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cpfm_pkg::FREQ_W-1:0]      rsp_freq_all,
   output logic [cpfm_pkg::FREQ_W-1:0]      rsp_freq_band,
   output logic [cpfm_pkg::CNT_W-1:0]       rsp_count_all,
   output logic [cpfm_pkg::CNT_W-1:0]       rsp_count_band,
   // Config port
   input  logic                             csr_we,
   input  logic [cpfm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cpfm_pkg::RATE_W-1:0]      csr_wdata
);

   localparam int SUM_W  = cpfm_pkg::SUM_W;
   localparam int CNT_W  = cpfm_pkg::CNT_W;
   localparam int NUM_W  = cpfm_pkg::NUM_W;
   localparam int STEP_W = cpfm_pkg::STEP_W;
   localparam int FREQ_W = cpfm_pkg::FREQ_W;

   localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(CNT_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // Control and config
   logic [1:0]                   state_ff, state_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [cpfm_pkg::RATE_W-1:0]  tick_rate_ff, tick_rate_in;
   logic [cpfm_pkg::BAND_W-1:0]  band_low_ff, band_low_in;
   logic [cpfm_pkg::BAND_W-1:0]  band_high_ff, band_high_in;

   // Accumulators
   logic [TIMER_WIDTH-1:0]       last_stamp_ff, last_stamp_in;
   logic [SUM_W-1:0]             total_sum_ff, total_sum_in;
   logic [CNT_W-1:0]             total_count_ff, total_count_in;
   logic [SUM_W-1:0]             band_sum_ff, band_sum_in;
   logic [CNT_W-1:0]             band_count_ff, band_count_in;

   // Shared multiplicand: scale times tick rate, shifted left each step
   logic [NUM_W-1:0]             mcand_ff, mcand_in;

   // Per-lane datapath, lane 0 all periods, lane 1 in-band periods
   logic [SUM_W-1:0]             div_ff [2];
   logic [SUM_W-1:0]             div_in [2];
   logic [CNT_W-1:0]             mlt_ff [2];
   logic [CNT_W-1:0]             mlt_in [2];
   logic [CNT_W-1:0]             cap_cnt_ff [2];
   logic [CNT_W-1:0]             cap_cnt_in [2];
   logic [NUM_W-1:0]             num_ff [2];
   logic [NUM_W-1:0]             num_in [2];
   logic [SUM_W-1:0]             rem_ff [2];
   logic [SUM_W-1:0]             rem_in [2];
   logic [FREQ_W-1:0]            quo_ff [2];
   logic [FREQ_W-1:0]            quo_in [2];
   logic                         ovf_ff [2];
   logic                         ovf_in [2];
   logic                         zero_ff [2];
   logic                         zero_in [2];

   // Per-lane combinational helpers
   logic [SUM_W-1:0]             lane_sum [2];
   logic [CNT_W-1:0]             lane_cnt [2];
   logic [SUM_W:0]               rem_sh [2];
   logic                         q_bit [2];
   logic [FREQ_W-1:0]            lane_freq [2];

   // Capture helpers
   logic [TIMER_WIDTH-1:0]       now_stamp;
   logic [TIMER_WIDTH-1:0]       period;
   logic [SUM_W-1:0]             period_ext;
   logic                         in_band;
   logic [cpfm_pkg::KMUL_W-1:0]  kmul;

   // Response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0]            freq_all_ff, freq_all_in;
   logic [FREQ_W-1:0]            freq_band_ff, freq_band_in;
   logic [CNT_W-1:0]             count_all_ff, count_all_in;
   logic [CNT_W-1:0]             count_band_ff, count_band_in;

   logic                         req_fire;
   logic                         rsp_free;

   // Assertion helpers
   logic                         read_fire;
   logic                         acc_clear;
   logic                         done_stall;
   logic                         rem_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;

   // Period from the previous stamp, wrapped at the timer width
   assign now_stamp  = TIMER_WIDTH'(req_stamp);
   assign period     = now_stamp - last_stamp_ff;
   assign period_ext = SUM_W'(period);
   assign in_band    = (period_ext > SUM_W'(band_low_ff)) &&
                       (period_ext < SUM_W'(band_high_ff));

   // Scale the tick rate once per read
   assign kmul = cpfm_pkg::KMUL_W'(tick_rate_ff) * cpfm_pkg::KMUL_W'(cpfm_pkg::SCALE);

   // Lane sources and one restoring-division step per lane
   always_comb begin
      lane_sum[0] = total_sum_ff;
      lane_cnt[0] = total_count_ff;
      lane_sum[1] = band_sum_ff;
      lane_cnt[1] = band_count_ff;
      for (int l = 0; l < 2; l++) begin
         rem_sh[l]    = {rem_ff[l], num_ff[l][NUM_W-1]};
         q_bit[l]     = (rem_sh[l] >= {1'b0, div_ff[l]});
         lane_freq[l] = zero_ff[l] ? '0 : (ovf_ff[l] ? '1 : quo_ff[l]);
      end
   end

   // Next-state logic
   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      tick_rate_in   = tick_rate_ff;
      band_low_in    = band_low_ff;
      band_high_in   = band_high_ff;
      last_stamp_in  = last_stamp_ff;
      total_sum_in   = total_sum_ff;
      total_count_in = total_count_ff;
      band_sum_in    = band_sum_ff;
      band_count_in  = band_count_ff;
      mcand_in       = mcand_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      freq_all_in    = freq_all_ff;
      freq_band_in   = freq_band_ff;
      count_all_in   = count_all_ff;
      count_band_in  = count_band_ff;
      for (int l = 0; l < 2; l++) begin
         div_in[l]     = div_ff[l];
         mlt_in[l]     = mlt_ff[l];
         cap_cnt_in[l] = cap_cnt_ff[l];
         num_in[l]     = num_ff[l];
         rem_in[l]     = rem_ff[l];
         quo_in[l]     = quo_ff[l];
         ovf_in[l]     = ovf_ff[l];
         zero_in[l]    = zero_ff[l];
      end

      // Config writes, unknown indexes dropped
      if (csr_we) begin
         case (csr_index)
            cpfm_pkg::CSR_TICK_RATE: tick_rate_in = csr_wdata;
            cpfm_pkg::CSR_BAND_LOW:  band_low_in  = cpfm_pkg::BAND_W'(csr_wdata);
            cpfm_pkg::CSR_BAND_HIGH: band_high_in = cpfm_pkg::BAND_W'(csr_wdata);
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_func == cpfm_pkg::FUNC_CAPTURE)) begin
               // Accumulate the period
               last_stamp_in  = now_stamp;
               total_sum_in   = total_sum_ff + period_ext;
               total_count_in = total_count_ff + CNT_W'(1);
               if (in_band) begin
                  band_sum_in   = band_sum_ff + period_ext;
                  band_count_in = band_count_ff + CNT_W'(1);
               end
            end else if (req_fire) begin
               // Snapshot both lanes and clear the accumulators
               for (int l = 0; l < 2; l++) begin
                  div_in[l]     = lane_sum[l];
                  mlt_in[l]     = lane_cnt[l];
                  cap_cnt_in[l] = lane_cnt[l];
                  num_in[l]     = '0;
                  rem_in[l]     = '0;
                  quo_in[l]     = '0;
                  ovf_in[l]     = 1'b0;
                  zero_in[l]    = (lane_cnt[l] == '0) ||
                                  (lane_sum[l] <= SUM_W'(lane_cnt[l]));
               end
               total_sum_in   = '0;
               total_count_in = '0;
               band_sum_in    = '0;
               band_count_in  = '0;
               mcand_in       = NUM_W'(kmul);
               step_in        = '0;
               state_in       = ST_MUL;
            end
         end
         ST_MUL: begin
            // Shift-add multiply by the count, one count bit per cycle
            for (int l = 0; l < 2; l++) begin
               num_in[l] = num_ff[l] + (mlt_ff[l][0] ? mcand_ff : '0);
               mlt_in[l] = mlt_ff[l] >> 1;
            end
            mcand_in = mcand_ff << 1;
            if (step_ff == MUL_LAST) begin
               step_in  = '0;
               state_in = ST_DIV;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle
            for (int l = 0; l < 2; l++) begin
               rem_in[l] = q_bit[l] ? SUM_W'(rem_sh[l] - {1'b0, div_ff[l]})
                                    : SUM_W'(rem_sh[l]);
               quo_in[l] = {quo_ff[l][FREQ_W-2:0], q_bit[l]};
               ovf_in[l] = ovf_ff[l] | quo_ff[l][FREQ_W-1];
               num_in[l] = num_ff[l] << 1;
            end
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE: begin
            // Load the response once the output register is free
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               freq_all_in   = lane_freq[0];
               freq_band_in  = lane_freq[1];
               count_all_in  = cap_cnt_ff[0];
               count_band_in = cap_cnt_ff[1];
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         tick_rate_ff   <= cpfm_pkg::TICK_RATE_RST;
         band_low_ff    <= cpfm_pkg::BAND_LOW_RST;
         band_high_ff   <= cpfm_pkg::BAND_HIGH_RST;
         last_stamp_ff  <= '0;
         total_sum_ff   <= '0;
         total_count_ff <= '0;
         band_sum_ff    <= '0;
         band_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         tick_rate_ff   <= tick_rate_in;
         band_low_ff    <= band_low_in;
         band_high_ff   <= band_high_in;
         last_stamp_ff  <= last_stamp_in;
         total_sum_ff   <= total_sum_in;
         total_count_ff <= total_count_in;
         band_sum_ff    <= band_sum_in;
         band_count_ff  <= band_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath and response payload registers
   always_ff @(posedge clock) begin
      mcand_ff      <= mcand_in;
      freq_all_ff   <= freq_all_in;
      freq_band_ff  <= freq_band_in;
      count_all_ff  <= count_all_in;
      count_band_ff <= count_band_in;
      for (int l = 0; l < 2; l++) begin
         div_ff[l]     <= div_in[l];
         mlt_ff[l]     <= mlt_in[l];
         cap_cnt_ff[l] <= cap_cnt_in[l];
         num_ff[l]     <= num_in[l];
         rem_ff[l]     <= rem_in[l];
         quo_ff[l]     <= quo_in[l];
         ovf_ff[l]     <= ovf_in[l];
         zero_ff[l]    <= zero_in[l];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_freq_all   = freq_all_ff;
   assign rsp_freq_band  = freq_band_ff;
   assign rsp_count_all  = count_all_ff;
   assign rsp_count_band = count_band_ff;

   // Conditions checked below
   assign read_fire  = req_fire && (req_func == cpfm_pkg::FUNC_READ);
   assign acc_clear  = (total_count_ff == '0) && (band_count_ff == '0) &&
                       (total_sum_ff == '0);
   assign done_stall = (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready;
   assign rem_ok     = ((rem_ff[0] < div_ff[0]) || (div_ff[0] == '0)) &&
                       ((rem_ff[1] < div_ff[1]) || (div_ff[1] == '0));

`include "assert_macros.svh"

   // A read clears the accumulators and starts the multiply
   `ASSERT_NEXT(a_read_clears, clock, reset, read_fire, (state_ff == ST_MUL) && acc_clear)
   // A finished read waits while the previous response is stalled
   `ASSERT_NEXT(a_done_holds, clock, reset, done_stall, state_ff == ST_DONE)
   // A new response only comes out of the final state
   `ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   // The remainder stays below a nonzero divisor while dividing
   `ASSERT_IMPLY(a_rem_bound, clock, reset, state_ff == ST_DIV, rem_ok)

endmodule

// ----- sim/capture_period_frequency_meter_unit_tb.sv -----
// Self-checking testbench for the capture period frequency meter unit.
// Depends on cpfm_pkg and the capture_period_frequency_meter_unit RTL;
// checks every read response against a built-in model of the meter, or a hand-computed one for typed rows.
module capture_period_frequency_meter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One read response, as the block returns it
   typedef struct packed {
      logic [cpfm_pkg::FREQ_W-1:0] freq_all;
      logic [cpfm_pkg::FREQ_W-1:0] freq_band;
      logic [cpfm_pkg::CNT_W-1:0]  count_all;
      logic [cpfm_pkg::CNT_W-1:0]  count_band;
   } readout_type;

   // One directed request; typed rows carry a hand-computed response
   typedef struct packed {
      logic                         func;
      logic [cpfm_pkg::STAMP_W-1:0] stamp;
      logic                         typed;
      readout_type                  want;
   } stim_row_type;

   localparam logic [cpfm_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int          N_ROWS           = 24;
   localparam int          RANDOM_PER_PHASE = 85;
   localparam int          N_PHASES         = 5;
   localparam int          READ_LATENCY     = 80;
   localparam readout_type EMPTY            = '0;

   // Directed requests at the reset settings (band 18181..22222, 1 MHz ticks)
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      // read straight after reset: nothing accumulated
      '{cpfm_pkg::FUNC_READ,    16'd0,     1'b1, '{32'd0, 32'd0, 16'd0, 16'd0}},
      // first capture measures from a stamp of zero
      '{cpfm_pkg::FUNC_CAPTURE, 16'd20000, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_CAPTURE, 16'd40000, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_CAPTURE, 16'd40001, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_READ,    16'd0,     1'b0, EMPTY},
      // mean period of one tick gives zero
      '{cpfm_pkg::FUNC_CAPTURE, 16'd40002, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_READ,    16'hFFFF,  1'b1, '{32'd0, 32'd0, 16'd1, 16'd0}},
      // repeated stamp: zero period
      '{cpfm_pkg::FUNC_CAPTURE, 16'd40002, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_READ,    16'd0,     1'b1, '{32'd0, 32'd0, 16'd1, 16'd0}},
      // timer wrap between stamps
      '{cpfm_pkg::FUNC_CAPTURE, 16'hFFF0,  1'b0, EMPTY},
      '{cpfm_pkg::FUNC_CAPTURE, 16'h0010,  1'b0, EMPTY},
      '{cpfm_pkg::FUNC_CAPTURE, 16'h0000,  1'b0, EMPTY},
      '{cpfm_pkg::FUNC_READ,    16'd0,     1'b0, EMPTY},
      // band edges: equal to low, just inside both, equal to high
      '{cpfm_pkg::FUNC_CAPTURE, 16'd18181, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_CAPTURE, 16'd36363, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_CAPTURE, 16'd58584, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_CAPTURE, 16'd15270, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_READ,    16'd0,     1'b0, EMPTY},
      // two-tick period overflows the frequency
      '{cpfm_pkg::FUNC_CAPTURE, 16'd15272, 1'b0, EMPTY},
      '{cpfm_pkg::FUNC_READ,    16'd0,     1'b1, '{32'hFFFF_FFFF, 32'd0, 16'd1, 16'd0}},
      // stamp extremes
      '{cpfm_pkg::FUNC_CAPTURE, 16'hFFFF,  1'b0, EMPTY},
      '{cpfm_pkg::FUNC_CAPTURE, 16'h0000,  1'b0, EMPTY},
      '{cpfm_pkg::FUNC_READ,    16'd0,     1'b0, EMPTY},
      // read right after a read
      '{cpfm_pkg::FUNC_READ,    16'd0,     1'b1, '{32'd0, 32'd0, 16'd0, 16'd0}}
   };

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_func  = cpfm_pkg::FUNC_CAPTURE;
   logic [cpfm_pkg::STAMP_W-1:0]   req_stamp = '0;
   logic                           rsp_ready = 1'b0;
   logic                           csr_we    = 1'b0;
   logic [cpfm_pkg::CSR_IDX_W-1:0] csr_index = cpfm_pkg::CSR_TICK_RATE;
   logic [cpfm_pkg::RATE_W-1:0]    csr_wdata = '0;
   logic                           req_ready;
   logic                           rsp_valid;
   logic [cpfm_pkg::FREQ_W-1:0]    rsp_freq_all;
   logic [cpfm_pkg::FREQ_W-1:0]    rsp_freq_band;
   logic [cpfm_pkg::CNT_W-1:0]     rsp_count_all;
   logic [cpfm_pkg::CNT_W-1:0]     rsp_count_band;

   // Meter model state and its copy of the registers
   logic [cpfm_pkg::RATE_W-1:0]  rate_cfg   = cpfm_pkg::TICK_RATE_RST;
   logic [cpfm_pkg::BAND_W-1:0]  lo_cfg     = cpfm_pkg::BAND_LOW_RST;
   logic [cpfm_pkg::BAND_W-1:0]  hi_cfg     = cpfm_pkg::BAND_HIGH_RST;
   logic [cpfm_pkg::STAMP_W-1:0] prev_stamp = '0;
   logic [cpfm_pkg::SUM_W-1:0]   all_sum    = '0;
   logic [cpfm_pkg::CNT_W-1:0]   all_cnt    = '0;
   logic [cpfm_pkg::SUM_W-1:0]   in_sum     = '0;
   logic [cpfm_pkg::CNT_W-1:0]   in_cnt     = '0;

   readout_type expected_readouts [$];
   readout_type head_readout;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          n_captures    = 0;
   int          n_reads       = 0;
   int          n_checked     = 0;
   int          n_errors      = 0;

   capture_period_frequency_meter_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_stamp      (req_stamp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_freq_all   (rsp_freq_all),
      .rsp_freq_band  (rsp_freq_band),
      .rsp_count_all  (rsp_count_all),
      .rsp_count_band (rsp_count_band),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Frequency times 10000 from a sum and count, zero when too short
   function automatic logic [cpfm_pkg::FREQ_W-1:0] scaled_freq(
         input logic [cpfm_pkg::SUM_W-1:0] sum,
         input logic [cpfm_pkg::CNT_W-1:0] cnt);
      logic [63:0] num;
      logic [63:0] quo;
      if (cnt == '0 || sum <= cpfm_pkg::SUM_W'(cnt))
         return '0;
      num = 64'(cpfm_pkg::SCALE) * 64'(rate_cfg) * 64'(cnt);
      quo = num / 64'(sum);
      if (quo > 64'hFFFF_FFFF)
         return '1;
      return quo[cpfm_pkg::FREQ_W-1:0];
   endfunction

   // Advance the meter model by one request; return 1 when it yields a response
   function automatic bit meter_step(input logic func,
                                     input logic [cpfm_pkg::STAMP_W-1:0] stamp,
                                     output readout_type res);
      logic [cpfm_pkg::STAMP_W-1:0] period;
      res = '0;
      if (func == cpfm_pkg::FUNC_CAPTURE) begin
         // period wraps with the 16-bit timer
         period     = stamp - prev_stamp;
         prev_stamp = stamp;
         all_sum    = all_sum + cpfm_pkg::SUM_W'(period);
         all_cnt    = all_cnt + cpfm_pkg::CNT_W'(1);
         if (period > lo_cfg && period < hi_cfg) begin
            in_sum = in_sum + cpfm_pkg::SUM_W'(period);
            in_cnt = in_cnt + cpfm_pkg::CNT_W'(1);
         end
         return 1'b0;
      end
      res.freq_all   = scaled_freq(all_sum, all_cnt);
      res.freq_band  = scaled_freq(in_sum, in_cnt);
      res.count_all  = all_cnt;
      res.count_band = in_cnt;
      all_sum = '0;
      all_cnt = '0;
      in_sum  = '0;
      in_cnt  = '0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $realtime, msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s: got 0x%08h, expected 0x%08h",
                                   n_checked, name, got, want));
   endtask

   // Write one register; caller drops the write enable after the last write
   task automatic write_reg(input logic [cpfm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cpfm_pkg::RATE_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         cpfm_pkg::CSR_TICK_RATE: rate_cfg = val;
         cpfm_pkg::CSR_BAND_LOW:  lo_cfg   = val[cpfm_pkg::BAND_W-1:0];
         cpfm_pkg::CSR_BAND_HIGH: hi_cfg   = val[cpfm_pkg::BAND_W-1:0];
         default: ;
      endcase
   endtask

   // Present one request, hold it until taken, then predict its effect
   task automatic send_request(input logic func, input logic [cpfm_pkg::STAMP_W-1:0] stamp,
                               input logic typed, input readout_type want);
      readout_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_stamp <= stamp;
      do @(posedge clock); while (!req_ready);
      if (meter_step(func, stamp, res)) begin
         expected_readouts.push_back(typed ? want : res);
         n_reads++;
      end else begin
         n_captures++;
      end
   endtask

   // Drop valid and hold until every response is in and the capture path is quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_readouts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Capture runs with periods around the band, short ones and noise, plus reads
   task automatic run_random(input int n);
      logic [cpfm_pkg::STAMP_W-1:0] period;
      int                           pick;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 15) begin
            send_request(cpfm_pkg::FUNC_READ, 16'($urandom), 1'b0, EMPTY);
         end else begin
            pick = $urandom_range(9);
            case (pick)
               0, 1, 2, 3: period = 16'($urandom_range(lo_cfg, hi_cfg));
               4: period = ($urandom_range(1) == 0) ? lo_cfg + 16'($urandom_range(2)) - 16'd1
                                                   : hi_cfg + 16'($urandom_range(2)) - 16'd1;
               5, 6: period = 16'($urandom_range(3));
               default: period = 16'($urandom);
            endcase
            send_request(cpfm_pkg::FUNC_CAPTURE, prev_stamp + period, 1'b0, EMPTY);
         end
      end
   endtask

   // Stall the response channel at the current rate
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // Compare each taken response with the oldest pending read
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readouts.size() == 0) begin
            report_mismatch("response with no read request pending");
         end else begin
            head_readout = expected_readouts.pop_front();
            check_field("freq_all",   rsp_freq_all,   head_readout.freq_all);
            check_field("freq_band",  rsp_freq_band,  head_readout.freq_band);
            check_field("count_all",  32'(rsp_count_all),  32'(head_readout.count_all));
            check_field("count_band", 32'(rsp_count_band), 32'(head_readout.count_band));
         end
         n_checked++;
      end
   end

   initial begin
      int lo_pick;
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      settle();

      // Walk the directed table at reset settings
      for (int r = 0; r < N_ROWS; r++)
         send_request(DIRECTED[r].func, DIRECTED[r].stamp, DIRECTED[r].typed,
                      DIRECTED[r].want);

      // Random phases, each with its own settings and flow-control mix
      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         case (p)
            0: begin
               write_reg(cpfm_pkg::CSR_TICK_RATE, 24'd16000000);
               write_reg(cpfm_pkg::CSR_BAND_LOW,  24'd0);
               write_reg(cpfm_pkg::CSR_BAND_HIGH, 24'd65535);
               write_reg(CSR_SPARE,               24'($urandom));
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               write_reg(cpfm_pkg::CSR_TICK_RATE, 24'd1);
               write_reg(cpfm_pkg::CSR_BAND_LOW,  {8'($urandom), 16'd100});
               write_reg(cpfm_pkg::CSR_BAND_HIGH, {8'($urandom), 16'd30000});
               send_idle_pct = 74;
               rsp_stall_pct = 0;
            end
            2: begin
               // zero tick rate and an inverted band
               write_reg(cpfm_pkg::CSR_TICK_RATE, 24'd0);
               write_reg(cpfm_pkg::CSR_BAND_LOW,  24'd65535);
               write_reg(cpfm_pkg::CSR_BAND_HIGH, 24'd0);
               send_idle_pct = 0;
               rsp_stall_pct = 74;
            end
            3: begin
               // equal edges leave the band empty
               write_reg(cpfm_pkg::CSR_TICK_RATE, 24'($urandom_range(1, 16000000)));
               write_reg(cpfm_pkg::CSR_BAND_LOW,  24'd12345);
               write_reg(cpfm_pkg::CSR_BAND_HIGH, 24'd12345);
               send_idle_pct = 20;
               rsp_stall_pct = 20;
            end
            default: begin
               lo_pick = $urandom_range(0, 40000);
               write_reg(cpfm_pkg::CSR_TICK_RATE, 24'($urandom_range(1, 16000000)));
               write_reg(cpfm_pkg::CSR_BAND_LOW,  24'(lo_pick));
               write_reg(cpfm_pkg::CSR_BAND_HIGH, 24'(lo_pick + $urandom_range(1, 25000)));
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         csr_we <= 1'b0;
         run_random(RANDOM_PER_PHASE);
      end

      // Drain outstanding reads, then watch for strays
      req_valid <= 1'b0;
      waited = 0;
      while (expected_readouts.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (READ_LATENCY) @(posedge clock);
      if (expected_readouts.size() != 0)
         report_mismatch($sformatf("%0d read responses never arrived",
                                   expected_readouts.size()));

      $display("Sent %0d captures and %0d reads, checked %0d responses,",
               n_captures, n_reads, n_checked);
      $display("over reset and %0d register settings with mixed sender/receiver stalls",
               N_PHASES);
      if (n_errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Hang guard
   initial begin
      #4_000_000;
      $display("Timeout waiting on the meter");
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- capture_period_frequency_meter_unit.f -----
+incdir+hw/rtl
hw/rtl/cpfm_pkg.sv
hw/rtl/capture_period_frequency_meter_unit.sv
sim/capture_period_frequency_meter_unit_tb.sv
